// ===== hw/rtl/strmq_pkg.sv =====
// Shared types, sizes and codes for the sparse-table range-minimum engine.
// Used by strmq_mem and sparse_table_range_minimum; no dependencies.
`timescale 1ns / 1ps

package strmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int VALUE_WIDTH  = 32;

    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ADDR_W    = LVL_W + IDX_W;
    localparam int MEM_DEPTH = LEVELS * MAX_ELEMENTS;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [LVL_W-1:0]              lvl_t;
    typedef logic [ADDR_W-1:0]             addr_t;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_APPEND = 2'd1,
        ST_QREAD  = 2'd2,
        ST_QDONE  = 2'd3
    } state_t;

    // One write port and two read ports per cycle.
    typedef struct packed {
        logic   we;
        addr_t  waddr;
        value_t wdata;
        logic   re;
        addr_t  raddr_a;
        addr_t  raddr_b;
    } mem_req_t;

    // Table entry (index, level) sits at level * MAX_ELEMENTS + index.
    function automatic addr_t mk_addr(lvl_t level, idx_t idx);
        return {level, idx};
    endfunction

endpackage

// ===== hw/rtl/sparse_table_range_minimum.sv =====
// Top level of the sparse-table range-minimum engine: control sequencer,
// output register and the table memory. Depends on strmq_pkg and strmq_mem.
`timescale 1ns / 1ps

// Range-minimum engine over up to 1024 signed 32-bit elements, kept as a sparse
// table in one memory of 11 x 1024 words. An append item (tuser 0) stores its
// value at the next index and then fills one higher table level per cycle from
// the level below, up through every level whose block ends at the new index
// (floor(log2(index + 1)) of them, at most 10); the memory's single write port
// sets that rate. A query item (tuser 1) is latched, then makes two parallel
// table reads, then compares into the output register. A query with left above
// right or right at or beyond the loaded count skips the reads and returns
// minimum zero with range_error set. A query holds in its last cycle for as
// long as an earlier result still waits unaccepted in the output register.
// Clear (tuser 2) and the unused code give no result. Items are accepted one
// at a time; a finished result waits in the output register while the next
// item is taken. The table needs no clearing pass: it is only read at entries
// already written.
module sparse_table_range_minimum
    import strmq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] value, [41:32] left_index,
                                   // [51:42] right_index, [55:52] zero
    input  logic [1:0]  s_tuser,   // [1:0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] minimum
    output logic        m_tuser    // [0] range_error
);

    state_t   state_reg, state_next;
    cnt_t     count_reg;
    idx_t     idx_reg;
    lvl_t     level_reg;
    value_t   last_min_reg;
    idx_t     left_reg, right_reg;
    cnt_t     span_reg;
    logic     err_reg;
    logic     out_valid_reg;
    value_t   out_min_reg;
    logic     out_err_reg;

    mem_req_t mem_req;
    value_t   rdata_a, rdata_b;

    logic     accept;
    func_t    func;
    value_t   in_value;
    idx_t     in_left, in_right;
    logic     full;
    logic     out_free;

    logic [CNT_W:0] idx_p1, len_cur, len_nxt;
    logic [CNT_W:0] diff_cur, diff_nxt;
    logic           more;
    value_t         app_min;
    lvl_t           q_level;
    cnt_t           second_full;
    value_t         q_min;
    logic           q_err;

    strmq_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);
    assign in_value = value_t'(s_tdata[31:0]);
    assign in_left  = s_tdata[41:32];
    assign in_right = s_tdata[51:42];
    assign full     = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign out_free = !out_valid_reg || m_tready;

    // Fill step at level_reg: block start = idx + 1 - 2^level.
    assign idx_p1   = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(1);
    assign len_cur  = (CNT_W+1)'(1) << level_reg;
    assign len_nxt  = len_cur << 1;
    assign diff_cur = idx_p1 - len_cur;
    assign diff_nxt = idx_p1 - len_nxt;
    assign more     = (level_reg < LVL_W'(LEVELS - 1)) && (len_nxt <= idx_p1);
    // Upper half of the block is the entry just written one level down.
    assign app_min  = (rdata_a < last_min_reg) ? rdata_a : last_min_reg;

    // Query level: floor(log2(span)), capped at the top level.
    always_comb begin
        q_level = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (span_reg[i]) begin
                q_level = LVL_W'(i);
            end
        end
        if (q_level > LVL_W'(LEVELS - 1)) begin
            q_level = LVL_W'(LEVELS - 1);
        end
    end

    assign second_full = CNT_W'(right_reg) + CNT_W'(1) - (CNT_W'(1) << q_level);
    assign q_min       = (rdata_a < rdata_b) ? rdata_a : rdata_b;
    assign q_err       = (in_left > in_right) || (CNT_W'(in_right) >= count_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (func == FUNC_APPEND) begin
                        if (!full && count_reg != '0) begin
                            state_next = ST_APPEND;
                        end
                    end else if (func == FUNC_QUERY) begin
                        state_next = q_err ? ST_QDONE : ST_QREAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_APPEND: begin
                if (!more) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QREAD: begin
                state_next = ST_QDONE;
            end
            ST_QDONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and memory requests.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        mem_req  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && func == FUNC_APPEND && !full) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = mk_addr('0, count_reg[IDX_W-1:0]);
                    mem_req.wdata = in_value;
                    if (count_reg != '0) begin
                        mem_req.re      = 1'b1;
                        mem_req.raddr_a = mk_addr('0, idx_t'(count_reg - CNT_W'(1)));
                    end
                end
            end
            ST_APPEND: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = mk_addr(level_reg, diff_cur[IDX_W-1:0]);
                mem_req.wdata = app_min;
                if (more) begin
                    mem_req.re      = 1'b1;
                    mem_req.raddr_a = mk_addr(level_reg, diff_nxt[IDX_W-1:0]);
                end
            end
            ST_QREAD: begin
                mem_req.re      = 1'b1;
                mem_req.raddr_a = mk_addr(q_level, left_reg);
                mem_req.raddr_b = mk_addr(q_level, second_full[IDX_W-1:0]);
            end
            ST_QDONE: begin
                mem_req = '0;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_QDONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && accept) begin
                if (func == FUNC_APPEND && !full) begin
                    count_reg <= count_reg + CNT_W'(1);
                    level_reg <= LVL_W'(1);
                end else if (func == FUNC_CLEAR) begin
                    count_reg <= '0;
                end
            end
            if (state_reg == ST_APPEND) begin
                level_reg <= level_reg + LVL_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept) begin
            if (func == FUNC_APPEND) begin
                idx_reg      <= count_reg[IDX_W-1:0];
                last_min_reg <= in_value;
            end
            if (func == FUNC_QUERY) begin
                left_reg  <= in_left;
                right_reg <= in_right;
                span_reg  <= CNT_W'(in_right) - CNT_W'(in_left) + CNT_W'(1);
                err_reg   <= q_err;
            end
        end
        if (state_reg == ST_APPEND) begin
            last_min_reg <= app_min;
        end
        if (state_reg == ST_QDONE && out_free) begin
            out_min_reg <= err_reg ? value_t'(0) : q_min;
            out_err_reg <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_min_reg;
    assign m_tuser  = out_err_reg;

    // An error result always carries a zero minimum.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero minimum");

    // The loaded count never passes the table size.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // Fill steps stay within the table levels.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_APPEND |-> level_reg != '0 && level_reg < LVL_W'(LEVELS))
        else $error("append level out of range");

    // Queries never write the table.
    a_query_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_QREAD || state_reg == ST_QDONE |-> !mem_req.we)
        else $error("table write during query");

    // A result is loaded only after the query's read cycle or a range error.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_QDONE && !$past(state_reg == ST_QDONE) |->
            $past(state_reg == ST_QREAD) || err_reg)
        else $error("query result without table read");

endmodule

// ===== hw/rtl/strmq_mem.sv =====
// Sparse table storage: one write port, two registered read ports.
// Depends on strmq_pkg for sizes and the request struct.
`timescale 1ns / 1ps

module strmq_mem
    import strmq_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output value_t   rdata_a,
    output value_t   rdata_b
);

    value_t mem [MEM_DEPTH];
    value_t rdata_a_reg;
    value_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Hold read data until the next read request.
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_a_reg <= mem[req.raddr_a];
            rdata_b_reg <= mem[req.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== tb/sparse_table_range_minimum_test.sv =====
// Self-checking stream testbench for the sparse-table range-minimum engine.
// Depends on strmq_pkg (func codes, widths) and the sparse_table_range_minimum RTL.
`timescale 1ns / 1ps

module sparse_table_range_minimum_test;
    import strmq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int QUIET_TAIL  = 24;    // room for the longest append to finish
    localparam int PRINT_CAP   = 30;

    typedef struct {
        value_t minimum;
        logic   range_error;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // [31:0] value, [41:32] left_index, [51:42] right_index
    logic [1:0]  s_tuser;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [31:0] minimum
    logic        m_tuser;   // [0] range_error

    sparse_table_range_minimum DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state: block minima per (start index, level) and the loaded count.
    value_t  block_min [MAX_ELEMENTS][LEVELS];
    int      loaded;
    answer_t pending_answers[$];

    // Idle percentages for the sender and the receiver; zero means no gaps.
    int send_idle_pct;
    int take_idle_pct;
    int stall_left = 0;

    int mismatches;
    int cycle_count;
    int appends_sent, queries_sent, clears_sent, nops_sent;
    int answers_checked, error_answers;

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic value_t lesser(value_t a, value_t b);
        return (a <= b) ? a : b;
    endfunction

    // Store one element and rebuild every block that ends at its index.
    function automatic void store_element(value_t v);
        int idx;
        int span;
        int start;
        if (loaded >= MAX_ELEMENTS)
            return;             // drop: array full
        idx = loaded;
        block_min[idx][0] = v;
        for (int lvl = 1; lvl < LEVELS; lvl++) begin
            span = 1 << lvl;
            if (span > idx + 1)
                break;
            start = idx + 1 - span;
            block_min[start][lvl] = lesser(block_min[start][lvl-1],
                                           block_min[start + span/2][lvl-1]);
        end
        loaded = idx + 1;
    endfunction

    // Cover [l, r] with two overlapping power-of-two blocks.
    function automatic answer_t answer_query(int l, int r);
        answer_t a;
        int      width;
        int      lvl;
        int      tail_start;
        a.minimum     = '0;
        a.range_error = 1'b1;
        if (l > r || r >= loaded)
            return a;
        width = r - l + 1;
        lvl   = 0;
        while (width > 1) begin
            width = width >> 1;
            lvl++;
        end
        if (lvl > LEVELS - 1)
            lvl = LEVELS - 1;
        tail_start    = r + 1 - (1 << lvl);
        a.minimum     = lesser(block_min[l][lvl], block_min[tail_start][lvl]);
        a.range_error = 1'b0;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic int idle_span(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);  // occasional long gap
        return $urandom_range(3, 1);
    endfunction

    // Mostly full-range values, with extremes and a narrow band to force ties.
    function automatic value_t random_value();
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1, 2: return value_t'(int'($urandom_range(16)) - 8);
            default: return value_t'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Drive one item, hold it until accepted, then update the predictor.
    task automatic send_item(func_t op, value_t v, idx_t l, idx_t r);
        int gap;
        gap = idle_span(send_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, r, l, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (op)
            FUNC_APPEND: begin
                store_element(v);
                appends_sent++;
            end
            FUNC_QUERY: begin
                pending_answers.push_back(answer_query(int'(l), int'(r)));
                queries_sent++;
            end
            FUNC_CLEAR: begin
                loaded = 0;         // table contents stay; rewritten before any read
                clears_sent++;
            end
            default: nops_sent++;
        endcase
    endtask

    // Unused fields carry random bits; the block must ignore them.
    task automatic append_value(value_t v);
        send_item(FUNC_APPEND, v, idx_t'($urandom), idx_t'($urandom));
    endtask

    task automatic query_range(int l, int r);
        send_item(FUNC_QUERY, value_t'($urandom), idx_t'(l), idx_t'(r));
    endtask

    task automatic send_other(func_t op);
        send_item(op, value_t'($urandom), idx_t'($urandom), idx_t'($urandom));
    endtask

    // Mostly in-range queries; the rest reversed, past the count, or arbitrary.
    task automatic send_random_query();
        int l;
        int r;
        if (loaded > 0 && $urandom_range(99) < 75) begin
            l = $urandom_range(loaded - 1, 0);
            r = $urandom_range(loaded - 1, l);
        end else begin
            case ($urandom_range(2))
                0: begin
                    l = $urandom_range(1023, 1);
                    r = $urandom_range(l - 1, 0);
                end
                1: begin
                    if (loaded < MAX_ELEMENTS) begin
                        r = $urandom_range(1023, loaded);
                        l = $urandom_range(r, 0);
                    end else begin
                        l = 1023;
                        r = $urandom_range(1022, 0);
                    end
                end
                default: begin
                    l = $urandom_range(1023);
                    r = $urandom_range(1023);
                end
            endcase
        end
        query_range(l, r);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, compare each accepted result in order.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result minimum=%0d range_error=%0b",
                                          $signed(m_tdata), m_tuser));
            end else begin
                answer_t want;
                want = pending_answers.pop_front();
                answers_checked++;
                if (want.range_error)
                    error_answers++;
                if (m_tdata !== want.minimum)
                    report_mismatch($sformatf("minimum %0d, expected %0d",
                                              $signed(m_tdata), want.minimum));
                if (m_tuser !== want.range_error)
                    report_mismatch($sformatf("range_error %0b, expected %0b",
                                              m_tuser, want.range_error));
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = idle_span(take_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty array, extreme values, every func code, reversed and out-of-range
    // queries, clear followed by a query.
    task automatic test_directed_cases();
        send_idle_pct = 20;
        take_idle_pct = 20;
        query_range(0, 0);                  // nothing loaded yet
        append_value(32'sh7FFF_FFFF);
        append_value(32'sh8000_0000);
        append_value(32'sh0000_0000);
        append_value(32'shFFFF_FFFF);
        append_value(32'sh0000_0001);
        query_range(0, 0);
        query_range(0, 4);
        query_range(1, 1);
        query_range(2, 4);
        query_range(0, 1);
        query_range(3, 1);                  // reversed
        query_range(0, 5);                  // right at the loaded count
        query_range(1023, 1023);
        query_range(0, 1023);
        send_other(FUNC_NOP);               // ignored, no result
        query_range(3, 4);
        send_other(FUNC_CLEAR);
        query_range(0, 0);                  // empty again
        append_value(-32'sd5);
        query_range(0, 0);
    endtask

    // Load the whole array with queries in between, then push past full and
    // query the last element and wide ranges; the full range uses the top level.
    task automatic test_fill_to_capacity();
        send_idle_pct = 25;
        take_idle_pct = 25;
        send_other(FUNC_CLEAR);
        while (loaded < MAX_ELEMENTS) begin
            if ($urandom_range(9) == 0)
                send_random_query();
            else
                append_value(random_value());
        end
        append_value(32'sh8000_0000);       // full: must be dropped
        append_value(random_value());
        query_range(0, 1023);
        query_range(1023, 1023);
        query_range(512, 1023);
        query_range(0, 1022);
        query_range(1, 1023);
        query_range(0, 511);
        repeat (30) send_random_query();
    endtask

    // Short random sequences with clears so the array keeps refilling from zero.
    task automatic test_random_mix(int count, int idle_pct);
        int pick;
        send_idle_pct = idle_pct;
        take_idle_pct = idle_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 3 || (loaded > 48 && pick < 10))
                send_other(FUNC_CLEAR);
            else if (pick < 14)
                send_other(FUNC_NOP);
            else if (pick < 60)
                append_value(random_value());
            else
                send_random_query();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        loaded   = 0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        mismatches    = 0;
        for (int i = 0; i < MAX_ELEMENTS; i++)
            for (int j = 0; j < LEVELS; j++)
                block_min[i][j] = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_fill_to_capacity();
        test_random_mix(80, 30);
        test_random_mix(40, 0);             // back to back, no gaps on either side

        // Drain: wait for every answer, then let any last append finish.
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (QUIET_TAIL) @(posedge aclk);
        if (pending_answers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));

        $display("covered %0d appends, %0d queries, %0d clears, %0d no-ops in %0d cycles",
                 appends_sent, queries_sent, clears_sent, nops_sent, cycle_count);
        $display("checked %0d results (%0d range errors), %0d mismatches",
                 answers_checked, error_answers, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/strmq_pkg.sv
hw/rtl/strmq_mem.sv
hw/rtl/sparse_table_range_minimum.sv
tb/sparse_table_range_minimum_test.sv
